[hw/rtl/pcfc_pkg.sv]
// shared constants, codes and types of the pyro channel fire controller
`default_nettype none

package pcfc_pkg;

  localparam int NUM_CHANNELS = 3;
  localparam int LINE_W       = 3;

  localparam int OP_W     = 3;
  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 10;
  localparam int STATUS_W = 2;
  localparam int DUR_W    = 16;
  localparam int THR_W    = 10;
  localparam int BCH_W    = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_USER_W  = OP_W;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam logic [DUR_W-1:0] DURATION_RST  = 16'd1000;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 10'd500;
  localparam logic [BCH_W-1:0] BACKUP_CH_RST = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DURATION  = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_BACKUP    = 2'd2
  } cfg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_ARM    = 3'd1,
    OP_DISARM = 3'd2,
    OP_FIRE   = 3'd3,
    OP_BACKUP = 3'd4,
    OP_QUERY  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NOT_ARMED   = 2'd1,
    ST_BAD_CHANNEL = 2'd2
  } status_t;

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic [THR_W-1:0] threshold;
    logic [BCH_W-1:0] backup_ch;
  } cfg_t;

  typedef struct packed {
    op_t                 op;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic              accepted;
    status_t           status;
    logic [LINE_W-1:0] fire_lines;
    logic              armed_flag;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/pcfc_cfg_regs.sv]
// configuration registers: fire duration, continuity threshold, backup channel
`default_nettype none

module pcfc_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [pcfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pcfc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output pcfc_pkg::cfg_t                           cfg
);

  pcfc_pkg::cfg_t cfg_r;
  pcfc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (pcfc_pkg::cfg_idx_t'(cfg_index))
        pcfc_pkg::CFG_DURATION:  cfg_nxt.duration  = cfg_wdata[pcfc_pkg::DUR_W-1:0];
        pcfc_pkg::CFG_THRESHOLD: cfg_nxt.threshold = cfg_wdata[pcfc_pkg::THR_W-1:0];
        pcfc_pkg::CFG_BACKUP:    cfg_nxt.backup_ch = cfg_wdata[pcfc_pkg::BCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duration  <= pcfc_pkg::DURATION_RST;
      cfg_r.threshold <= pcfc_pkg::THRESHOLD_RST;
      cfg_r.backup_ch <= pcfc_pkg::BACKUP_CH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hw/rtl/pcfc_engine.sv]
// channel state (armed flag, fire lines, elapsed counts) and per-beat result logic
`default_nettype none

module pcfc_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pcfc_pkg::cfg_t    cfg,
  input  wire pcfc_pkg::item_t   item,
  input  wire logic              advance,
  output pcfc_pkg::result_t      res
);

  localparam int N = pcfc_pkg::NUM_CHANNELS;

  logic                          armed_r;
  logic                          armed_nxt;
  logic [N-1:0]                  firing_r;
  logic [N-1:0]                  firing_nxt;
  logic [pcfc_pkg::DUR_W-1:0]    elapsed_r   [N];
  logic [pcfc_pkg::DUR_W-1:0]    elapsed_nxt [N];

  logic [N-1:0] ch_hit;
  logic [N-1:0] bk_hit;
  logic         ch_ok;
  logic         bk_ok;
  logic         acc;
  pcfc_pkg::status_t status;
  logic [pcfc_pkg::LINE_W-1:0] lines;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ch_hit[i] = (int'(item.channel) == i + 1);
      bk_hit[i] = (int'(cfg.backup_ch) == i + 1);
    end
    ch_ok = |ch_hit;
    bk_ok = |bk_hit;
  end

  always_comb begin
    armed_nxt  = armed_r;
    firing_nxt = firing_r;
    for (int i = 0; i < N; i++) begin
      elapsed_nxt[i] = elapsed_r[i];
    end
    acc    = 1'b1;
    status = pcfc_pkg::ST_OK;
    case (item.op)
      pcfc_pkg::OP_TICK: begin
        for (int i = 0; i < N; i++) begin
          if (firing_r[i]) begin
            if (elapsed_r[i] < cfg.duration) begin
              elapsed_nxt[i] = elapsed_r[i] + {{(pcfc_pkg::DUR_W-1){1'b0}}, 1'b1};
            end else begin
              elapsed_nxt[i] = cfg.duration;
            end
            if (elapsed_nxt[i] == cfg.duration) begin
              firing_nxt[i] = 1'b0;
            end
          end
        end
      end
      pcfc_pkg::OP_ARM: begin
        armed_nxt = 1'b1;
      end
      pcfc_pkg::OP_DISARM: begin
        armed_nxt  = 1'b0;
        firing_nxt = '0;
        for (int i = 0; i < N; i++) begin
          elapsed_nxt[i] = '0;
        end
      end
      pcfc_pkg::OP_FIRE: begin
        if (!armed_r) begin
          acc    = 1'b0;
          status = pcfc_pkg::ST_NOT_ARMED;
        end else if (!ch_ok) begin
          acc    = 1'b0;
          status = pcfc_pkg::ST_BAD_CHANNEL;
        end else begin
          for (int i = 0; i < N; i++) begin
            if (ch_hit[i]) begin
              firing_nxt[i]  = 1'b1;
              elapsed_nxt[i] = '0;
            end
          end
        end
      end
      pcfc_pkg::OP_BACKUP: begin
        if (!bk_ok) begin
          acc    = 1'b0;
          status = pcfc_pkg::ST_BAD_CHANNEL;
        end else begin
          for (int i = 0; i < N; i++) begin
            if (bk_hit[i]) begin
              firing_nxt[i]  = 1'b1;
              elapsed_nxt[i] = '0;
            end
          end
        end
      end
      pcfc_pkg::OP_QUERY: begin
        if (!ch_ok) begin
          acc    = 1'b0;
          status = pcfc_pkg::ST_BAD_CHANNEL;
        end else begin
          acc = (item.sample > cfg.threshold);
        end
      end
      default: ;
    endcase
  end

  // channels beyond the field width run but are not shown
  always_comb begin
    lines = '0;
    for (int i = 0; i < pcfc_pkg::LINE_W; i++) begin
      if (i < N) begin
        lines[i] = firing_nxt[i];
      end
    end
  end

  assign res.accepted   = acc;
  assign res.status     = status;
  assign res.fire_lines = lines;
  assign res.armed_flag = armed_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      firing_r <= '0;
      for (int i = 0; i < N; i++) begin
        elapsed_r[i] <= '0;
      end
    end else if (advance) begin
      armed_r  <= armed_nxt;
      firing_r <= firing_nxt;
      for (int i = 0; i < N; i++) begin
        elapsed_r[i] <= elapsed_nxt[i];
      end
    end
  end

  a_disarm_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.op == pcfc_pkg::OP_DISARM |=> !armed_r && firing_r == '0)
    else $error("disarm left a line or the armed flag set");

  a_arm_sets: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.op == pcfc_pkg::OP_ARM |=> armed_r)
    else $error("arm did not set the armed flag");

  a_tick_never_raises: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.op == pcfc_pkg::OP_TICK |=> (firing_r & ~$past(firing_r)) == '0)
    else $error("tick raised a fire line");

endmodule

`default_nettype wire

[hw/rtl/pyro_channel_fire_controller.sv]
// top level: input beat register, fire engine, result register, config port
//
//   channel  | direction | contents
//   in_      | slave     | tuser: op[2:0]; tdata: channel[2:0], cont_sample[12:3]
//   out_     | master    | tdata: accepted[0], status[2:1], fire_lines[5:3], armed_flag[6]
//   cfg_     | write     | index 0 fire duration, 1 continuity threshold, 2 backup channel
//
// one beat per cycle sustained unless the output stalls; input register, then result register
// state updates as a beat moves from the input register into the result register
// a stalled result holds in its register while one more beat waits in the input register
// reset is synchronous: both stages empty, disarmed, lines off, counts zero, config defaults
`default_nettype none

module pyro_channel_fire_controller (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [pcfc_pkg::IN_USER_W-1:0]        in_tuser,   // op
  input  wire logic [pcfc_pkg::IN_DATA_W-1:0]        in_tdata,   // channel, cont_sample
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [pcfc_pkg::OUT_DATA_W-1:0]            out_tdata,  // accepted, status, fire_lines, armed_flag
  input  wire logic                                  cfg_we,
  input  wire logic [pcfc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [pcfc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int RES_W = $bits(pcfc_pkg::result_t);

  pcfc_pkg::cfg_t    cfg;
  pcfc_pkg::item_t   s_item_r;
  pcfc_pkg::result_t res;
  pcfc_pkg::result_t out_res_r;
  logic              s_valid_r;
  logic              out_valid_r;
  logic              advance;
  logic              in_take;

  pcfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pcfc_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (s_item_r),
    .advance (advance),
    .res     (res)
  );

  assign advance   = s_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s_valid_r <= 1'b1;
      end else if (advance) begin
        s_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_item_r.op      <= pcfc_pkg::op_t'(in_tuser[pcfc_pkg::OP_W-1:0]);
      s_item_r.channel <= in_tdata[pcfc_pkg::CH_W-1:0];
      s_item_r.sample  <= in_tdata[pcfc_pkg::CH_W +: pcfc_pkg::SAMPLE_W];
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(pcfc_pkg::OUT_DATA_W-RES_W){1'b0}},
                       out_res_r.armed_flag,
                       out_res_r.fire_lines,
                       out_res_r.status,
                       out_res_r.accepted};

  a_advance_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("beat left the input register without reaching the result register");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r && out_valid_r && !out_tready |=> s_valid_r && $stable(s_item_r))
    else $error("waiting beat lost during output stall");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s_valid_r |-> in_tready)
    else $error("input refused with the input register empty");

endmodule

`default_nettype wire

[sim/pyro_channel_fire_controller_test.sv]
// testbench of the pyro channel fire controller: directed rows, then random beats against a predictor
`timescale 1ns / 100ps

module pyro_channel_fire_controller_test;

  localparam logic [pcfc_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [pcfc_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 4;

  typedef struct {
    bit                            is_cfg;
    pcfc_pkg::cfg_idx_t            idx;
    logic [pcfc_pkg::DUR_W-1:0]    val;
    logic [pcfc_pkg::OP_W-1:0]     op;
    logic [pcfc_pkg::CH_W-1:0]     ch;
    logic [pcfc_pkg::SAMPLE_W-1:0] smp;
    bit                            typed;
    pcfc_pkg::result_t             want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [pcfc_pkg::IN_USER_W-1:0] in_tuser = '0;
  logic [pcfc_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [pcfc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [pcfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pcfc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  pyro_channel_fire_controller dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted block state and config
  logic [pcfc_pkg::DUR_W-1:0] dur_reg = pcfc_pkg::DURATION_RST;
  logic [pcfc_pkg::THR_W-1:0] thr_reg = pcfc_pkg::THRESHOLD_RST;
  logic [pcfc_pkg::BCH_W-1:0] bch_reg = pcfc_pkg::BACKUP_CH_RST;
  bit               arm_state;
  bit               line_on [pcfc_pkg::NUM_CHANNELS];
  int unsigned      line_count [pcfc_pkg::NUM_CHANNELS];

  pcfc_pkg::result_t pending_results[$];
  row_t    directed_rows[$];
  int      errors = 0;
  int      burst_left = 0;
  int      cycles = 0;

  // receiver stall state
  int      rx_cycle = 0;
  int      hold_left = 0;
  int      mode = 0;
  int      mode_left = 0;

  function automatic bit chan_valid(input logic [pcfc_pkg::CH_W-1:0] ch);
    return ch >= 1 && ch <= pcfc_pkg::NUM_CHANNELS;
  endfunction

  function automatic pcfc_pkg::result_t step_fire_state(
      input logic [pcfc_pkg::OP_W-1:0] op,
      input logic [pcfc_pkg::CH_W-1:0] ch,
      input logic [pcfc_pkg::SAMPLE_W-1:0] smp);
    pcfc_pkg::result_t r;
    r.accepted = 1'b1;
    r.status   = pcfc_pkg::ST_OK;
    case (op)
      pcfc_pkg::OP_TICK: begin
        for (int i = 0; i < pcfc_pkg::NUM_CHANNELS; i++) begin
          if (line_on[i]) begin
            if (line_count[i] < 32'(dur_reg)) line_count[i]++;
            if (line_count[i] > 32'(dur_reg)) line_count[i] = 32'(dur_reg);
            if (line_count[i] >= 32'(dur_reg)) line_on[i] = 1'b0;
          end
        end
      end
      pcfc_pkg::OP_ARM: arm_state = 1'b1;
      pcfc_pkg::OP_DISARM: begin
        arm_state = 1'b0;
        for (int i = 0; i < pcfc_pkg::NUM_CHANNELS; i++) begin
          line_on[i] = 1'b0;
          line_count[i] = 0;
        end
      end
      pcfc_pkg::OP_FIRE: begin
        if (!arm_state) begin
          r.accepted = 1'b0;
          r.status   = pcfc_pkg::ST_NOT_ARMED;
        end else if (!chan_valid(ch)) begin
          r.accepted = 1'b0;
          r.status   = pcfc_pkg::ST_BAD_CHANNEL;
        end else begin
          line_on[ch-1] = 1'b1;
          line_count[ch-1] = 0;
        end
      end
      pcfc_pkg::OP_BACKUP: begin
        if (!chan_valid({1'b0, bch_reg})) begin
          r.accepted = 1'b0;
          r.status   = pcfc_pkg::ST_BAD_CHANNEL;
        end else begin
          line_on[bch_reg-1] = 1'b1;
          line_count[bch_reg-1] = 0;
        end
      end
      pcfc_pkg::OP_QUERY: begin
        if (!chan_valid(ch)) begin
          r.accepted = 1'b0;
          r.status   = pcfc_pkg::ST_BAD_CHANNEL;
        end else begin
          r.accepted = smp > thr_reg;
        end
      end
      default: ;
    endcase
    r.fire_lines = '0;
    for (int i = 0; i < pcfc_pkg::NUM_CHANNELS && i < pcfc_pkg::LINE_W; i++) begin
      r.fire_lines[i] = line_on[i];
    end
    r.armed_flag = arm_state;
    return r;
  endfunction

  function automatic row_t cfg_row(input pcfc_pkg::cfg_idx_t idx,
                                   input logic [pcfc_pkg::DUR_W-1:0] val);
    row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    r.op     = '0;
    r.ch     = '0;
    r.smp    = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic row_t cmd_row(input logic [pcfc_pkg::OP_W-1:0] op,
                                   input logic [pcfc_pkg::CH_W-1:0] ch,
                                   input logic [pcfc_pkg::SAMPLE_W-1:0] smp);
    row_t r;
    r.is_cfg = 1'b0;
    r.idx    = pcfc_pkg::CFG_DURATION;
    r.val    = '0;
    r.op     = op;
    r.ch     = ch;
    r.smp    = smp;
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic row_t chk_row(input logic [pcfc_pkg::OP_W-1:0] op,
                                   input logic [pcfc_pkg::CH_W-1:0] ch,
                                   input logic [pcfc_pkg::SAMPLE_W-1:0] smp, input logic acc,
                                   input pcfc_pkg::status_t st,
                                   input logic [pcfc_pkg::LINE_W-1:0] lines,
                                   input logic armed);
    row_t r;
    r = cmd_row(op, ch, smp);
    r.typed = 1'b1;
    r.want  = '{accepted: acc, status: st, fire_lines: lines, armed_flag: armed};
    return r;
  endfunction

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input pcfc_pkg::cfg_idx_t idx,
                           input logic [pcfc_pkg::DUR_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pcfc_pkg::CFG_DURATION:  dur_reg = val;
      pcfc_pkg::CFG_THRESHOLD: thr_reg = val[pcfc_pkg::THR_W-1:0];
      pcfc_pkg::CFG_BACKUP:    bch_reg = val[pcfc_pkg::BCH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_cmd(input logic [pcfc_pkg::OP_W-1:0] op,
                          input logic [pcfc_pkg::CH_W-1:0] ch,
                          input logic [pcfc_pkg::SAMPLE_W-1:0] smp, input bit typed,
                          input pcfc_pkg::result_t want);
    int gap;
    pcfc_pkg::result_t got;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, smp, ch};
    do @(posedge clk); while (!in_tready);
    got = step_fire_state(op, ch, smp);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic send_random();
    int pick;
    logic [pcfc_pkg::OP_W-1:0] op;
    logic [pcfc_pkg::CH_W-1:0] ch;
    logic [pcfc_pkg::SAMPLE_W-1:0] smp;
    pick = $urandom_range(0, 99);
    ch   = ($urandom_range(0, 4) == 0) ? pcfc_pkg::CH_W'($urandom_range(0, 7)) :
                                         pcfc_pkg::CH_W'($urandom_range(1, pcfc_pkg::NUM_CHANNELS));
    smp  = pcfc_pkg::SAMPLE_W'($urandom_range(0, 1023));
    if (pick < 38)      op = pcfc_pkg::OP_TICK;
    else if (pick < 47) op = pcfc_pkg::OP_ARM;
    else if (pick < 52) op = pcfc_pkg::OP_DISARM;
    else if (pick < 72) op = pcfc_pkg::OP_FIRE;
    else if (pick < 79) op = pcfc_pkg::OP_BACKUP;
    else if (pick < 94) begin
      op = pcfc_pkg::OP_QUERY;
      if ($urandom_range(0, 1) == 0) begin
        smp = pcfc_pkg::SAMPLE_W'(32'(thr_reg) + $urandom_range(0, 2) - 1);
      end
    end else op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
    send_cmd(op, ch, smp, 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    pcfc_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_tdata[0]);
          errors++;
        end
        if (out_tdata[2:1] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[2:1]);
          errors++;
        end
        if (out_tdata[5:3] !== want.fire_lines) begin
          $error("fire_lines: expected %b, got %b", want.fire_lines, out_tdata[5:3]);
          errors++;
        end
        if (out_tdata[6] !== want.armed_flag) begin
          $error("armed_flag: expected %0d, got %0d", want.armed_flag, out_tdata[6]);
          errors++;
        end
      end
    end
  end

  // receiver: its own stall pattern plus two long hold-offs
  always @(posedge clk) begin : drive_ready
    rx_cycle++;
    if (rx_cycle == 600 || rx_cycle == 2500) hold_left = 300;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end else begin
        mode_left--;
      end
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t r;
    int dpick;
    for (int i = 0; i < pcfc_pkg::NUM_CHANNELS; i++) begin
      line_on[i] = 1'b0;
      line_count[i] = 0;
    end
    arm_state = 1'b0;

    directed_rows.push_back(chk_row(pcfc_pkg::OP_TICK, 3'd0, 10'd0,
                                    1'b1, pcfc_pkg::ST_OK, 3'b000, 1'b0));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_FIRE, 3'd0, 10'd0,
                                    1'b0, pcfc_pkg::ST_NOT_ARMED, 3'b000, 1'b0));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_FIRE, 3'd7, 10'd1023,
                                    1'b0, pcfc_pkg::ST_NOT_ARMED, 3'b000, 1'b0));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_ARM, 3'd0, 10'd0,
                                    1'b1, pcfc_pkg::ST_OK, 3'b000, 1'b1));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_FIRE, 3'd0, 10'd0,
                                    1'b0, pcfc_pkg::ST_BAD_CHANNEL, 3'b000, 1'b1));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_FIRE, 3'd4, 10'd0,
                                    1'b0, pcfc_pkg::ST_BAD_CHANNEL, 3'b000, 1'b1));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_FIRE, 3'd1, 10'd0,
                                    1'b1, pcfc_pkg::ST_OK, 3'b001, 1'b1));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_QUERY, 3'd0, 10'd1023,
                                    1'b0, pcfc_pkg::ST_BAD_CHANNEL, 3'b001, 1'b1));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_QUERY, 3'd2, 10'd1023,
                                    1'b1, pcfc_pkg::ST_OK, 3'b001, 1'b1));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_QUERY, 3'd2, 10'd500,
                                    1'b0, pcfc_pkg::ST_OK, 3'b001, 1'b1));
    directed_rows.push_back(chk_row(OP_SPARE6, 3'd0, 10'd0,
                                    1'b1, pcfc_pkg::ST_OK, 3'b001, 1'b1));
    directed_rows.push_back(chk_row(OP_SPARE7, 3'd7, 10'd1023,
                                    1'b1, pcfc_pkg::ST_OK, 3'b001, 1'b1));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_BACKUP, 3'd0, 10'd0,
                                    1'b1, pcfc_pkg::ST_OK, 3'b101, 1'b1));
    directed_rows.push_back(cmd_row(pcfc_pkg::OP_TICK, 3'd0, 10'd0));
    directed_rows.push_back(cmd_row(pcfc_pkg::OP_FIRE, 3'd1, 10'd0));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_DISARM, 3'd0, 10'd0,
                                    1'b1, pcfc_pkg::ST_OK, 3'b000, 1'b0));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_BACKUP, 3'd0, 10'd0,
                                    1'b1, pcfc_pkg::ST_OK, 3'b100, 1'b0));
    directed_rows.push_back(cfg_row(pcfc_pkg::CFG_DURATION, 16'd0));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_TICK, 3'd0, 10'd0,
                                    1'b1, pcfc_pkg::ST_OK, 3'b000, 1'b0));
    directed_rows.push_back(cfg_row(pcfc_pkg::CFG_DURATION, 16'd5));
    directed_rows.push_back(cfg_row(pcfc_pkg::CFG_BACKUP, 16'd0));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_BACKUP, 3'd0, 10'd0,
                                    1'b0, pcfc_pkg::ST_BAD_CHANNEL, 3'b000, 1'b0));
    directed_rows.push_back(cmd_row(pcfc_pkg::OP_ARM, 3'd0, 10'd0));
    directed_rows.push_back(cmd_row(pcfc_pkg::OP_FIRE, 3'd2, 10'd0));
    directed_rows.push_back(cmd_row(pcfc_pkg::OP_TICK, 3'd0, 10'd0));
    directed_rows.push_back(cmd_row(pcfc_pkg::OP_TICK, 3'd0, 10'd0));
    directed_rows.push_back(cmd_row(pcfc_pkg::OP_TICK, 3'd0, 10'd0));
    directed_rows.push_back(cfg_row(pcfc_pkg::CFG_DURATION, 16'd1));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_TICK, 3'd0, 10'd0,
                                    1'b1, pcfc_pkg::ST_OK, 3'b000, 1'b1));
    directed_rows.push_back(cfg_row(pcfc_pkg::CFG_THRESHOLD, 16'd0));
    directed_rows.push_back(cfg_row(pcfc_pkg::CFG_BACKUP, 16'd1));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_QUERY, 3'd3, 10'd0,
                                    1'b0, pcfc_pkg::ST_OK, 3'b000, 1'b1));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_QUERY, 3'd3, 10'd1,
                                    1'b1, pcfc_pkg::ST_OK, 3'b000, 1'b1));
    directed_rows.push_back(cmd_row(pcfc_pkg::OP_BACKUP, 3'd0, 10'd0));
    directed_rows.push_back(cfg_row(pcfc_pkg::CFG_THRESHOLD, 16'd1023));
    directed_rows.push_back(chk_row(pcfc_pkg::OP_QUERY, 3'd1, 10'd1023,
                                    1'b0, pcfc_pkg::ST_OK, 3'b001, 1'b1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      r = directed_rows[k];
      if (r.is_cfg) write_reg(r.idx, r.val);
      else send_cmd(r.op, r.ch, r.smp, r.typed, r.want);
    end

    // random phases, each with its own register setting
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        write_reg(pcfc_pkg::CFG_DURATION, 16'd1);
        write_reg(pcfc_pkg::CFG_THRESHOLD, 16'd0);
        write_reg(pcfc_pkg::CFG_BACKUP, 16'd0);
      end else if (phase == 1) begin
        write_reg(pcfc_pkg::CFG_DURATION, 16'hffff);
        write_reg(pcfc_pkg::CFG_THRESHOLD, 16'd1023);
        write_reg(pcfc_pkg::CFG_BACKUP, 16'd3);
      end else begin
        dpick = $urandom_range(0, 9);
        write_reg(pcfc_pkg::CFG_DURATION,
                  (dpick == 0) ? 16'd0 :
                  (dpick == 1) ? pcfc_pkg::DUR_W'($urandom_range(0, 16'hffff)) :
                  pcfc_pkg::DUR_W'($urandom_range(1, 12)));
        write_reg(pcfc_pkg::CFG_THRESHOLD, pcfc_pkg::DUR_W'($urandom_range(0, 1023)));
        write_reg(pcfc_pkg::CFG_BACKUP, pcfc_pkg::DUR_W'($urandom_range(0, 3)));
      end
      repeat (100) send_random();
    end

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/pcfc_pkg.sv
hw/rtl/pcfc_cfg_regs.sv
hw/rtl/pcfc_engine.sv
hw/rtl/pyro_channel_fire_controller.sv
sim/pyro_channel_fire_controller_test.sv
